[rtl/sst_pkg.sv]
// Shared types and constants for the source text tokenizer.
package sst_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CLASS_W = 3;
    localparam int unsigned START_W = 16;
    localparam int unsigned LEN_W   = 8;
    localparam int unsigned LINE_W  = 16;

    // result queue
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_PTR_W = 2;
    localparam int unsigned FIFO_CNT_W = 3;

    typedef enum logic [CLASS_W-1:0] {
        CLS_ID       = 3'd0,
        CLS_SYM      = 3'd1,
        CLS_INT      = 3'd2,
        CLS_FLOAT    = 3'd3,
        CLS_END      = 3'd4,
        CLS_BAD      = 3'd5,
        CLS_UNCLOSED = 3'd6
    } tok_class_t;

    typedef enum logic [7:0] {
        MODE_IDLE      = 8'b0000_0001,
        MODE_ID        = 8'b0000_0010,
        MODE_NUM       = 8'b0000_0100,
        MODE_SLASH     = 8'b0000_1000,
        MODE_DOT       = 8'b0001_0000,
        MODE_LINECOM   = 8'b0010_0000,
        MODE_BLOCK     = 8'b0100_0000,
        MODE_BLOCKSTAR = 8'b1000_0000
    } scan_mode_t;

    localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [BYTE_W-1:0] CH_0     = 8'h30;
    localparam logic [BYTE_W-1:0] CH_9     = 8'h39;
    localparam logic [BYTE_W-1:0] CH_EQ    = 8'h3D;
    localparam logic [BYTE_W-1:0] CH_UA    = 8'h41;
    localparam logic [BYTE_W-1:0] CH_UZ    = 8'h5A;
    localparam logic [BYTE_W-1:0] CH_LA    = 8'h61;
    localparam logic [BYTE_W-1:0] CH_LZ    = 8'h7A;

    typedef struct packed {
        logic [CLASS_W-1:0] token_class;
        logic [START_W-1:0] token_start;
        logic [LEN_W-1:0]   token_length;
        logic [LINE_W-1:0]  token_line;
        logic [BYTE_W-1:0]  single_char;
        logic               last_of_run;
    } tok_t;

    // results produced by one accepted byte, in order
    typedef struct packed {
        logic [1:0] count;
        tok_t       first;
        tok_t       second;
    } push_t;

endpackage

[rtl/sst_byte_if.sv]
// Input channel: one text byte per word.
interface sst_byte_if;
    logic                          valid;
    logic                          ready;
    logic [sst_pkg::BYTE_W-1:0]    text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink   (input valid, input text_byte, output ready);
endinterface

[rtl/sst_token_if.sv]
// Output channel: one token per word.
interface sst_token_if;
    logic                          valid;
    logic                          ready;
    logic [sst_pkg::CLASS_W-1:0]   token_class;
    logic [sst_pkg::START_W-1:0]   token_start;
    logic [sst_pkg::LEN_W-1:0]     token_length;
    logic [sst_pkg::LINE_W-1:0]    token_line;
    logic [sst_pkg::BYTE_W-1:0]    single_char;
    logic                          last_of_run;

    modport source (output valid, output token_class, output token_start,
                    output token_length, output token_line, output single_char,
                    output last_of_run, input ready);
    modport sink   (input valid, input token_class, input token_start,
                    input token_length, input token_line, input single_char,
                    input last_of_run, output ready);
endinterface

[rtl/sst_scan.sv]
// Scanner state and per-byte token recognition.
module sst_scan #(
    parameter int unsigned POSITION_BITS = 16,
    parameter int unsigned LENGTH_BITS   = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    sst_byte_if.sink            text_in,
    input  logic                space_ok,
    output sst_pkg::push_t      push
);

    sst_pkg::scan_mode_t        mode_reg, mode_next;
    logic [POSITION_BITS-1:0]   pos_reg, pos_next;
    logic [POSITION_BITS-1:0]   start_reg, start_next;
    logic [LENGTH_BITS-1:0]     len_reg, len_next;
    logic [POSITION_BITS-1:0]   line_reg, line_next;
    logic                       point_reg, point_next;

    logic                       fire;
    logic [sst_pkg::BYTE_W-1:0] c;
    logic                       is_digit, is_alpha, is_sym;
    logic [LENGTH_BITS-1:0]     len_inc;
    logic [POSITION_BITS-1:0]   line_inc;
    logic                       again;

    logic                       r0_v, r1_v;
    sst_pkg::tok_class_t        r0_cls, r1_cls;
    logic [POSITION_BITS-1:0]   r0_start, r1_start;
    logic [LENGTH_BITS-1:0]     r0_len, r1_len;
    logic [sst_pkg::BYTE_W-1:0] r0_ch, r1_ch;
    sst_pkg::tok_t              tok0, tok1;

    function automatic logic [sst_pkg::START_W-1:0] clamp_pos(
        input logic [POSITION_BITS-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        clamp_pos = (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
    endfunction

    function automatic logic [sst_pkg::LEN_W-1:0] clamp_len(
        input logic [LENGTH_BITS-1:0] v);
        logic [15:0] w;
        w = 16'(v);
        clamp_len = (w > 16'h00FF) ? 8'hFF : w[7:0];
    endfunction

    assign fire          = text_in.valid && text_in.ready;
    assign text_in.ready = space_ok;
    assign c             = text_in.text_byte;

    assign is_digit = (c >= sst_pkg::CH_0) && (c <= sst_pkg::CH_9);
    assign is_alpha = ((c >= sst_pkg::CH_LA) && (c <= sst_pkg::CH_LZ)) ||
                      ((c >= sst_pkg::CH_UA) && (c <= sst_pkg::CH_UZ));
    assign is_sym   = (c == sst_pkg::CH_PLUS) || (c == sst_pkg::CH_MINUS) ||
                      (c == sst_pkg::CH_STAR) || (c == sst_pkg::CH_EQ);

    assign len_inc  = (len_reg == '1) ? len_reg : len_reg + LENGTH_BITS'(1);
    assign line_inc = (line_reg == '1) ? line_reg : line_reg + POSITION_BITS'(1);

    always_comb
    begin
        mode_next  = mode_reg;
        pos_next   = pos_reg;
        start_next = start_reg;
        len_next   = len_reg;
        line_next  = line_reg;
        point_next = point_reg;
        again      = 1'b0;
        r0_v       = 1'b0;
        r0_cls     = sst_pkg::CLS_ID;
        r0_start   = start_reg;
        r0_len     = len_reg;
        r0_ch      = sst_pkg::CH_NUL;
        r1_v       = 1'b0;
        r1_cls     = sst_pkg::CLS_ID;
        r1_start   = pos_reg;
        r1_len     = LENGTH_BITS'(1);
        r1_ch      = sst_pkg::CH_NUL;

        // finish or extend the token in progress
        unique case (mode_reg) inside
            sst_pkg::MODE_ID:
            begin
                if (is_alpha || is_digit)
                begin
                    len_next = len_inc;
                end
                else
                begin
                    r0_v  = 1'b1;
                    again = 1'b1;
                end
            end
            sst_pkg::MODE_NUM:
            begin
                if (is_digit)
                begin
                    len_next = len_inc;
                end
                else if (c == sst_pkg::CH_DOT && !point_reg)
                begin
                    point_next = 1'b1;
                    len_next   = len_inc;
                end
                else
                begin
                    r0_v   = 1'b1;
                    r0_cls = point_reg ? sst_pkg::CLS_FLOAT : sst_pkg::CLS_INT;
                    again  = 1'b1;
                end
            end
            sst_pkg::MODE_SLASH:
            begin
                if (c == sst_pkg::CH_SLASH)
                begin
                    mode_next = sst_pkg::MODE_LINECOM;
                end
                else if (c == sst_pkg::CH_STAR)
                begin
                    mode_next = sst_pkg::MODE_BLOCK;
                end
                else
                begin
                    r0_v   = 1'b1;
                    r0_cls = sst_pkg::CLS_SYM;
                    r0_len = LENGTH_BITS'(1);
                    r0_ch  = sst_pkg::CH_SLASH;
                    again  = 1'b1;
                end
            end
            sst_pkg::MODE_DOT:
            begin
                if (is_digit)
                begin
                    mode_next  = sst_pkg::MODE_NUM;
                    point_next = 1'b1;
                    len_next   = len_inc;
                end
                else
                begin
                    r0_v   = 1'b1;
                    r0_cls = sst_pkg::CLS_BAD;
                    r0_len = LENGTH_BITS'(1);
                    r0_ch  = sst_pkg::CH_DOT;
                    again  = 1'b1;
                end
            end
            sst_pkg::MODE_LINECOM:
            begin
                if (c == sst_pkg::CH_NUL)
                begin
                    again = 1'b1;
                end
                else if (c == sst_pkg::CH_LF)
                begin
                    line_next = line_inc;
                    mode_next = sst_pkg::MODE_IDLE;
                end
            end
            sst_pkg::MODE_BLOCK, sst_pkg::MODE_BLOCKSTAR:
            begin
                if (c == sst_pkg::CH_NUL)
                begin
                    r0_v   = 1'b1;
                    r0_cls = sst_pkg::CLS_UNCLOSED;
                    r0_len = '0;
                    again  = 1'b1;
                end
                else if (c == sst_pkg::CH_STAR)
                begin
                    mode_next = sst_pkg::MODE_BLOCKSTAR;
                end
                else if (c == sst_pkg::CH_SLASH && mode_reg == sst_pkg::MODE_BLOCKSTAR)
                begin
                    mode_next = sst_pkg::MODE_IDLE;
                end
                else
                begin
                    if (c == sst_pkg::CH_LF)
                    begin
                        line_next = line_inc;
                    end
                    mode_next = sst_pkg::MODE_BLOCK;
                end
            end
            default:
            begin
                again = 1'b1;
            end
        endcase

        // byte seen from between tokens
        if (again)
        begin
            mode_next = sst_pkg::MODE_IDLE;
            if (c == sst_pkg::CH_NUL)
            begin
                r1_v   = 1'b1;
                r1_cls = sst_pkg::CLS_END;
                r1_len = '0;
            end
            else if (c == sst_pkg::CH_SPACE || c == sst_pkg::CH_TAB)
            begin
                mode_next = sst_pkg::MODE_IDLE;
            end
            else if (c == sst_pkg::CH_LF)
            begin
                line_next = line_inc;
            end
            else if (c == sst_pkg::CH_SLASH || c == sst_pkg::CH_DOT || is_digit || is_alpha)
            begin
                if (c == sst_pkg::CH_SLASH)
                begin
                    mode_next = sst_pkg::MODE_SLASH;
                end
                else if (c == sst_pkg::CH_DOT)
                begin
                    mode_next = sst_pkg::MODE_DOT;
                end
                else if (is_digit)
                begin
                    mode_next = sst_pkg::MODE_NUM;
                end
                else
                begin
                    mode_next = sst_pkg::MODE_ID;
                end
                start_next = pos_reg;
                len_next   = LENGTH_BITS'(1);
                point_next = 1'b0;
            end
            else
            begin
                r1_v   = 1'b1;
                r1_cls = is_sym ? sst_pkg::CLS_SYM : sst_pkg::CLS_BAD;
                r1_ch  = c;
            end
        end

        // end of text restarts everything
        if (c == sst_pkg::CH_NUL)
        begin
            mode_next  = sst_pkg::MODE_IDLE;
            pos_next   = '0;
            start_next = '0;
            len_next   = '0;
            line_next  = '0;
            point_next = 1'b0;
        end
        else if (pos_reg != '1)
        begin
            pos_next = pos_reg + POSITION_BITS'(1);
        end
    end

    always_comb
    begin
        tok0.token_class  = r0_cls;
        tok0.token_start  = clamp_pos(r0_start);
        tok0.token_length = clamp_len(r0_len);
        tok0.token_line   = clamp_pos(line_reg);
        tok0.single_char  = r0_ch;
        tok0.last_of_run  = 1'b0;
        tok1.token_class  = r1_cls;
        tok1.token_start  = clamp_pos(r1_start);
        tok1.token_length = clamp_len(r1_len);
        tok1.token_line   = clamp_pos(line_reg);
        tok1.single_char  = r1_ch;
        tok1.last_of_run  = 1'b1;

        push.count  = fire ? ({1'b0, r0_v} + {1'b0, r1_v}) : 2'd0;
        push.second = tok1;
        if (r0_v)
        begin
            push.first             = tok0;
            push.first.last_of_run = !r1_v;
        end
        else
        begin
            push.first = tok1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= sst_pkg::MODE_IDLE;
            pos_reg   <= '0;
            start_reg <= '0;
            len_reg   <= '0;
            line_reg  <= '0;
            point_reg <= 1'b0;
        end
        else if (fire)
        begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
            len_reg   <= len_next;
            line_reg  <= line_next;
            point_reg <= point_next;
        end
    end

`ifndef SYNTHESIS
    a_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        fire && c == sst_pkg::CH_NUL |=>
            pos_reg == '0 && line_reg == '0 && mode_reg == sst_pkg::MODE_IDLE)
        else $error("scanner state not cleared after end of text");

    a_pos_advance: assert property (@(posedge clk) disable iff (!rst_n)
        fire && c != sst_pkg::CH_NUL && pos_reg != '1 |=>
            pos_reg == $past(pos_reg) + POSITION_BITS'(1))
        else $error("byte offset did not advance");
`endif

endmodule

[rtl/sst_fifo.sv]
// Result queue: takes up to two tokens per cycle, hands out one.
module sst_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  sst_pkg::push_t      push,
    output logic                space_ok,
    sst_token_if.source         token_out
);

    sst_pkg::tok_t                      mem [sst_pkg::FIFO_DEPTH];
    logic [sst_pkg::FIFO_PTR_W-1:0]     wr_reg, rd_reg;
    logic [sst_pkg::FIFO_CNT_W-1:0]     cnt_reg;
    logic                               pop;
    sst_pkg::tok_t                      head;

    // room for two words before accepting another byte
    assign space_ok = cnt_reg <= sst_pkg::FIFO_CNT_W'(sst_pkg::FIFO_DEPTH - 2);
    assign pop      = token_out.valid && token_out.ready;
    assign head     = mem[rd_reg];

    assign token_out.valid        = cnt_reg != '0;
    assign token_out.token_class  = head.token_class;
    assign token_out.token_start  = head.token_start;
    assign token_out.token_length = head.token_length;
    assign token_out.token_line   = head.token_line;
    assign token_out.single_char  = head.single_char;
    assign token_out.last_of_run  = head.last_of_run;

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem[wr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem[wr_reg + sst_pkg::FIFO_PTR_W'(1)] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_reg + sst_pkg::FIFO_PTR_W'(push.count);
            rd_reg  <= rd_reg + sst_pkg::FIFO_PTR_W'(pop);
            cnt_reg <= cnt_reg + sst_pkg::FIFO_CNT_W'(push.count)
                               - sst_pkg::FIFO_CNT_W'(pop);
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push.count != 2'd0 |-> cnt_reg <= sst_pkg::FIFO_CNT_W'(sst_pkg::FIFO_DEPTH - 2))
        else $error("result queue written without room");

    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        pop && push.count == 2'd0 |=>
            cnt_reg == $past(cnt_reg) - sst_pkg::FIFO_CNT_W'(1))
        else $error("result queue count lost a pop");
`endif

endmodule

[rtl/source_text_tokenizer.sv]
// Top level of the source text tokenizer: scanner plus result queue.
//
// Usage:
//   text_in   - byte channel (valid/ready). One word is one text byte; a
//               zero byte ends the text and resets offset and line to zero.
//   token_out - token channel (valid/ready). One word is one token: class,
//               start offset, length, line, single character, last_of_run.
//   A byte yields zero, one or two tokens; last_of_run marks the final token
//   caused by a given byte. Run tokens come on the byte after their last.
// Latency: a token appears on token_out in the cycle after the byte that
//   completes it is accepted (empty queue, receiver ready).
// Throughput: one byte per cycle. Tokens leave at one per cycle through a
//   four-word queue; text_in.ready drops while fewer than two words are
//   free, so a receiver stall or a run of two-token bytes backs up input.
// Reset: rst_n asynchronous, active low; scanner returns to between-tokens,
//   offset and line zero; the queue empties.
// Offsets and line count saturate at 2^POSITION_BITS-1 internally and are
//   clamped to 16 bits on output; lengths saturate at 2^LENGTH_BITS-1 and
//   are clamped to 8 bits.
module source_text_tokenizer #(
    parameter int unsigned POSITION_BITS = 16,
    parameter int unsigned LENGTH_BITS   = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    sst_byte_if.sink    text_in,
    sst_token_if.source token_out
);

    // tokens from one byte, toward the queue
    sst_pkg::push_t push;
    // queue can absorb a worst-case byte
    logic           space_ok;

    sst_scan #(
        .POSITION_BITS (POSITION_BITS),
        .LENGTH_BITS   (LENGTH_BITS)
    ) u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .text_in  (text_in),
        .space_ok (space_ok),
        .push     (push)
    );

    sst_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .space_ok  (space_ok),
        .token_out (token_out)
    );

endmodule

[verif/source_text_tokenizer_tb.sv]
// Testbench for the source text tokenizer: byte driver, token monitor, scanner predictor.
module source_text_tokenizer_tb;

    // Run limits. CYCLE_LIMIT lies far above what a correct run of about a thousand
    // bytes needs, even with two tokens per byte and every stall.
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned QUIET_TAIL   = 150;   // last bytes sent with no idling
    localparam int unsigned HOLD_AT_TOK  = 120;   // token count that starts the long stall
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned MAX_REPORTS  = 50;

    // Saturation points at the default parameters (16-bit positions, 8-bit lengths).
    localparam logic [sst_pkg::START_W-1:0] POS_MAX = '1;
    localparam logic [sst_pkg::LEN_W-1:0]   LEN_MAX = '1;

    // Bytes that the package leaves out.
    localparam logic [sst_pkg::BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [sst_pkg::BYTE_W-1:0] CH_UNDER = 8'h5F;

    logic clk = 1'b0;
    logic rst_n;

    sst_byte_if  text_if ();
    sst_token_if token_if ();

    source_text_tokenizer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .text_in   (text_if),
        .token_out (token_if)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor: a software copy of the scanner state.
    // ------------------------------------------------------------------
    sst_pkg::scan_mode_t            scan_q;
    logic [sst_pkg::START_W-1:0]    offset_q;     // offset of the next byte
    logic [sst_pkg::START_W-1:0]    tok_start_q;
    logic [sst_pkg::LEN_W-1:0]      tok_len_q;
    logic [sst_pkg::LINE_W-1:0]     line_q;
    logic                           point_q;

    sst_pkg::tok_t pending_tok [2];               // tokens caused by the byte being scanned
    int            pending_n;

    sst_pkg::tok_t expected_tokens [$];           // tokens still owed by the block
    logic [sst_pkg::BYTE_W-1:0] text_q [$];       // bytes not yet offered

    int unsigned total_bytes;
    int unsigned sent_cnt;
    int unsigned tok_cnt;
    int unsigned err_cnt;
    int unsigned cycle_cnt;
    int unsigned hold_left;
    logic        hold_fired;

    function automatic logic is_digit(input logic [sst_pkg::BYTE_W-1:0] c);
        return (c >= sst_pkg::CH_0) && (c <= sst_pkg::CH_9);
    endfunction

    function automatic logic is_alpha(input logic [sst_pkg::BYTE_W-1:0] c);
        return ((c >= sst_pkg::CH_LA) && (c <= sst_pkg::CH_LZ)) ||
               ((c >= sst_pkg::CH_UA) && (c <= sst_pkg::CH_UZ));
    endfunction

    task automatic clear_scan();
        scan_q      = sst_pkg::MODE_IDLE;
        offset_q    = '0;
        tok_start_q = '0;
        tok_len_q   = '0;
        line_q      = '0;
        point_q     = 1'b0;
    endtask

    task automatic add_token(input sst_pkg::tok_class_t cls,
                             input logic [sst_pkg::START_W-1:0] start,
                             input logic [sst_pkg::LEN_W-1:0] len,
                             input logic [sst_pkg::BYTE_W-1:0] ch);
        sst_pkg::tok_t t;
        t.token_class  = cls;
        t.token_start  = start;
        t.token_length = len;
        t.token_line   = line_q;
        t.single_char  = ch;
        t.last_of_run  = 1'b0;
        pending_tok[pending_n] = t;
        pending_n++;
    endtask

    task automatic bump_line();
        if (line_q != POS_MAX)
            line_q++;
    endtask

    task automatic grow_run();
        if (tok_len_q != LEN_MAX)
            tok_len_q++;
    endtask

    task automatic open_run(input sst_pkg::scan_mode_t m);
        scan_q      = m;
        tok_start_q = offset_q;
        tok_len_q   = sst_pkg::LEN_W'(1);
        point_q     = 1'b0;
    endtask

    // Byte seen between tokens (also the re-scan of a byte that ended a token).
    task automatic scan_idle(input logic [sst_pkg::BYTE_W-1:0] c);
        scan_q = sst_pkg::MODE_IDLE;
        if (c == sst_pkg::CH_NUL)
            add_token(sst_pkg::CLS_END, offset_q, '0, sst_pkg::CH_NUL);
        else if (c == sst_pkg::CH_SPACE || c == sst_pkg::CH_TAB)
            ;
        else if (c == sst_pkg::CH_LF)
            bump_line();
        else if (c == sst_pkg::CH_SLASH)
            open_run(sst_pkg::MODE_SLASH);
        else if (c == sst_pkg::CH_DOT)
            open_run(sst_pkg::MODE_DOT);
        else if (is_digit(c))
            open_run(sst_pkg::MODE_NUM);
        else if (is_alpha(c))
            open_run(sst_pkg::MODE_ID);
        else if (c == sst_pkg::CH_PLUS || c == sst_pkg::CH_MINUS ||
                 c == sst_pkg::CH_STAR || c == sst_pkg::CH_EQ)
            add_token(sst_pkg::CLS_SYM, offset_q, sst_pkg::LEN_W'(1), c);
        else
            add_token(sst_pkg::CLS_BAD, offset_q, sst_pkg::LEN_W'(1), c);
    endtask

    // Advance the predictor by one accepted byte and queue what it owes.
    task automatic scan_byte(input logic [sst_pkg::BYTE_W-1:0] c);
        logic rescan;
        int   k;
        rescan    = 1'b0;
        pending_n = 0;
        case (scan_q) inside
            sst_pkg::MODE_ID:
                if (is_alpha(c) || is_digit(c))
                    grow_run();
                else
                begin
                    add_token(sst_pkg::CLS_ID, tok_start_q, tok_len_q, sst_pkg::CH_NUL);
                    rescan = 1'b1;
                end
            sst_pkg::MODE_NUM:
                if (is_digit(c))
                    grow_run();
                else if (c == sst_pkg::CH_DOT && !point_q)
                begin
                    point_q = 1'b1;
                    grow_run();
                end
                else
                begin
                    add_token(point_q ? sst_pkg::CLS_FLOAT : sst_pkg::CLS_INT,
                              tok_start_q, tok_len_q, sst_pkg::CH_NUL);
                    rescan = 1'b1;
                end
            sst_pkg::MODE_SLASH:
                if (c == sst_pkg::CH_SLASH)
                    scan_q = sst_pkg::MODE_LINECOM;
                else if (c == sst_pkg::CH_STAR)
                    scan_q = sst_pkg::MODE_BLOCK;
                else
                begin
                    add_token(sst_pkg::CLS_SYM, tok_start_q, sst_pkg::LEN_W'(1),
                              sst_pkg::CH_SLASH);
                    rescan = 1'b1;
                end
            sst_pkg::MODE_DOT:
                if (is_digit(c))
                begin
                    // point then digit: a float that starts at the point
                    scan_q  = sst_pkg::MODE_NUM;
                    point_q = 1'b1;
                    grow_run();
                end
                else
                begin
                    add_token(sst_pkg::CLS_BAD, tok_start_q, sst_pkg::LEN_W'(1),
                              sst_pkg::CH_DOT);
                    rescan = 1'b1;
                end
            sst_pkg::MODE_LINECOM:
                if (c == sst_pkg::CH_NUL)
                    rescan = 1'b1;
                else if (c == sst_pkg::CH_LF)
                begin
                    bump_line();
                    scan_q = sst_pkg::MODE_IDLE;
                end
            sst_pkg::MODE_BLOCK, sst_pkg::MODE_BLOCKSTAR:
                if (c == sst_pkg::CH_NUL)
                begin
                    // text ended inside a block comment
                    add_token(sst_pkg::CLS_UNCLOSED, tok_start_q, '0, sst_pkg::CH_NUL);
                    rescan = 1'b1;
                end
                else if (c == sst_pkg::CH_STAR)
                    scan_q = sst_pkg::MODE_BLOCKSTAR;
                else if (c == sst_pkg::CH_SLASH && scan_q == sst_pkg::MODE_BLOCKSTAR)
                    scan_q = sst_pkg::MODE_IDLE;
                else
                begin
                    if (c == sst_pkg::CH_LF)
                        bump_line();
                    scan_q = sst_pkg::MODE_BLOCK;
                end
            default:
                rescan = 1'b1;
        endcase

        if (rescan)
            scan_idle(c);

        // end of text starts a fresh text at offset 0, line 0
        if (c == sst_pkg::CH_NUL)
            clear_scan();
        else if (offset_q != POS_MAX)
            offset_q++;

        if (pending_n > 0)
            pending_tok[pending_n-1].last_of_run = 1'b1;
        for (k = 0; k < pending_n; k++)
            expected_tokens.insert(expected_tokens.size(), pending_tok[k]);
    endtask

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    task automatic put_byte(input logic [sst_pkg::BYTE_W-1:0] b);
        text_q.insert(text_q.size(), b);
    endtask

    task automatic push_str(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            put_byte(s[i]);
    endtask

    function automatic logic [sst_pkg::BYTE_W-1:0] rand_alpha();
        if ($urandom_range(0, 1) == 0)
            return sst_pkg::BYTE_W'($urandom_range(sst_pkg::CH_LA, sst_pkg::CH_LZ));
        return sst_pkg::BYTE_W'($urandom_range(sst_pkg::CH_UA, sst_pkg::CH_UZ));
    endfunction

    function automatic logic [sst_pkg::BYTE_W-1:0] rand_digit();
        return sst_pkg::BYTE_W'($urandom_range(sst_pkg::CH_0, sst_pkg::CH_9));
    endfunction

    task automatic push_digits(input int n);
        int i;
        for (i = 0; i < n; i++)
            put_byte(rand_digit());
    endtask

    task automatic push_ident(input int n);
        int i;
        put_byte(rand_alpha());
        for (i = 1; i < n; i++)
            put_byte(($urandom_range(0, 3) == 0) ? rand_digit() : rand_alpha());
    endtask

    task automatic push_noise(input int n);
        int i;
        for (i = 0; i < n; i++)
            put_byte(sst_pkg::BYTE_W'($urandom_range(1, 255)));
    endtask

    // One text of mostly well-formed tokens with random content, then a zero byte.
    task automatic add_random_text();
        int i;
        int n_tok;
        int i2;
        n_tok = $urandom_range(3, 30);
        for (i = 0; i < n_tok; i++)
        begin
            case ($urandom_range(0, 15)) inside
                0, 1, 2: push_ident($urandom_range(1, 8));
                3, 4:    push_digits($urandom_range(1, 5));
                5:
                begin
                    push_digits($urandom_range(1, 4));
                    put_byte(sst_pkg::CH_DOT);
                    push_digits($urandom_range(0, 3));
                end
                6:
                begin
                    put_byte(sst_pkg::CH_DOT);
                    push_digits($urandom_range(1, 3));
                end
                7:
                    case ($urandom_range(0, 4))
                        0: put_byte(sst_pkg::CH_PLUS);
                        1: put_byte(sst_pkg::CH_MINUS);
                        2: put_byte(sst_pkg::CH_STAR);
                        3: put_byte(sst_pkg::CH_EQ);
                        default: put_byte(sst_pkg::CH_SLASH);
                    endcase
                8:
                begin
                    push_str("//");
                    push_noise($urandom_range(0, 10));
                    put_byte(sst_pkg::CH_LF);
                end
                9:
                begin
                    push_str("/*");
                    for (i2 = $urandom_range(0, 10); i2 > 0; i2--)
                        case ($urandom_range(0, 3))
                            0: put_byte(sst_pkg::CH_STAR);
                            1: put_byte(sst_pkg::CH_LF);
                            2: put_byte(rand_alpha());
                            default: push_noise(1);
                        endcase
                    push_str("*/");
                end
                10:
                    case ($urandom_range(0, 2))
                        0: put_byte(CH_UNDER);
                        1: put_byte(CH_CR);
                        default: put_byte(sst_pkg::BYTE_W'($urandom_range(8'h80, 8'hFF)));
                    endcase
                11: push_noise($urandom_range(1, 3));
                12: put_byte(($urandom_range(0, 1) == 0) ? sst_pkg::CH_SLASH : sst_pkg::CH_DOT);
                default: ;
            endcase
            case ($urandom_range(0, 5)) inside
                0, 1: put_byte(sst_pkg::CH_SPACE);
                2:    put_byte(sst_pkg::CH_TAB);
                3:    put_byte(sst_pkg::CH_LF);
                default: ;   // tokens run together
            endcase
        end
        // a few texts end inside a comment or in the middle of a token
        case ($urandom_range(0, 7))
            0:
            begin
                push_str("/*");
                push_noise($urandom_range(0, 3));
            end
            1:
            begin
                push_str("//");
                push_noise($urandom_range(0, 3));
            end
            2: push_ident($urandom_range(1, 3));
            default: ;
        endcase
        put_byte(sst_pkg::CH_NUL);
    endtask

    // ------------------------------------------------------------------
    // Idling windows: bursts allowed in most of the run, with quiet stretches
    // and none at all near the end.
    // ------------------------------------------------------------------
    function automatic logic idle_allowed();
        return (sent_cnt + QUIET_TAIL < total_bytes) && ((sent_cnt % 1024) < 768);
    endfunction

    // Byte driver
    int unsigned tx_gap;
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            text_if.valid     <= 1'b0;
            text_if.text_byte <= sst_pkg::CH_NUL;
            tx_gap = 0;
        end
        else
        begin
            if (text_if.valid && text_if.ready)
            begin
                scan_byte(text_if.text_byte);
                sent_cnt <= sent_cnt + 1;
            end
            // a word on offer that was not taken stays as it is
            if (!text_if.valid || text_if.ready)
            begin
                if (tx_gap != 0)
                begin
                    tx_gap = tx_gap - 1;
                    text_if.valid <= 1'b0;
                end
                else if (text_q.size() != 0 && idle_allowed() && hold_left == 0 &&
                         $urandom_range(0, 7) == 0)
                begin
                    tx_gap = $urandom_range(0, 4);
                    text_if.valid <= 1'b0;
                end
                else if (text_q.size() != 0)
                begin
                    text_if.valid     <= 1'b1;
                    text_if.text_byte <= text_q.pop_front();
                end
                else
                    text_if.valid <= 1'b0;
            end
        end
    end

    // Long receiver stall, once, while the driver keeps offering bytes:
    // the result queue fills and text_in.ready must drop.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            hold_left  <= 0;
            hold_fired <= 1'b0;
        end
        else if (!hold_fired && tok_cnt >= HOLD_AT_TOK)
        begin
            hold_left  <= HOLD_CYCLES;
            hold_fired <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    task automatic check_field(input string name, input logic [sst_pkg::LINE_W-1:0] want,
                               input logic [sst_pkg::LINE_W-1:0] got);
        if (want !== got)
        begin
            if (err_cnt < MAX_REPORTS)
                $display("%0t: token %0d %s expected %0h got %0h", $time, tok_cnt, name,
                         want, got);
            err_cnt++;
        end
    endtask

    // Token monitor
    int unsigned   rx_gap;
    sst_pkg::tok_t want_tok;
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            token_if.ready <= 1'b0;
            rx_gap = 0;
        end
        else
        begin
            if (token_if.valid && token_if.ready)
            begin
                if (expected_tokens.size() == 0)
                begin
                    if (err_cnt < MAX_REPORTS)
                        $display("%0t: token %0d expected none got class %0h start %0h",
                                 $time, tok_cnt, token_if.token_class, token_if.token_start);
                    err_cnt++;
                end
                else
                begin
                    want_tok = expected_tokens.pop_front();
                    check_field("class",  sst_pkg::LINE_W'(want_tok.token_class),
                                sst_pkg::LINE_W'(token_if.token_class));
                    check_field("start",  want_tok.token_start, token_if.token_start);
                    check_field("length", sst_pkg::LINE_W'(want_tok.token_length),
                                sst_pkg::LINE_W'(token_if.token_length));
                    check_field("line",   want_tok.token_line, token_if.token_line);
                    check_field("char",   sst_pkg::LINE_W'(want_tok.single_char),
                                sst_pkg::LINE_W'(token_if.single_char));
                    check_field("last",   sst_pkg::LINE_W'(want_tok.last_of_run),
                                sst_pkg::LINE_W'(token_if.last_of_run));
                end
                tok_cnt <= tok_cnt + 1;
            end

            if (hold_left != 0)
                token_if.ready <= 1'b0;
            else if (rx_gap != 0)
            begin
                rx_gap = rx_gap - 1;
                token_if.ready <= 1'b0;
            end
            else if (idle_allowed() && $urandom_range(0, 5) == 0)
            begin
                rx_gap = $urandom_range(0, 4);
                token_if.ready <= 1'b0;
            end
            else
                token_if.ready <= 1'b1;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Stimulus, reset and end of run
    initial
    begin
        int unsigned mark;

        rst_n             = 1'b0;
        text_if.valid     = 1'b0;
        text_if.text_byte = sst_pkg::CH_NUL;
        token_if.ready    = 1'b0;
        sent_cnt          = 0;
        tok_cnt           = 0;
        err_cnt           = 0;
        cycle_cnt         = 0;
        clear_scan();

        // Directed text: identifier, integer, float with a trailing point,
        // a float that starts at a point, a point before a symbol, a held slash
        // before an identifier, a closed block comment, an empty line comment,
        // bad bytes (underscore, CR, 0x80, 0xFF), symbols, a token cut by the
        // end of text, then an unclosed block comment.
        push_str("Az9 7 1. .5.+/x/**/");
        put_byte(sst_pkg::CH_LF);
        push_str("//");
        put_byte(sst_pkg::CH_LF);
        put_byte(CH_UNDER);
        put_byte(CH_CR);
        put_byte(8'h80);
        put_byte(8'hFF);
        push_str("-=");
        put_byte(sst_pkg::CH_TAB);
        push_str("k");
        put_byte(sst_pkg::CH_NUL);
        push_str("/*a");
        put_byte(sst_pkg::CH_LF);
        push_str("*");
        put_byte(sst_pkg::CH_NUL);

        // First random part, with one over-long identifier and number
        // so that token_length saturates.
        mark = text_q.size();
        push_ident(300);
        put_byte(sst_pkg::CH_SPACE);
        push_digits(150);
        put_byte(sst_pkg::CH_DOT);
        push_digits(150);
        put_byte(sst_pkg::CH_NUL);
        while (text_q.size() < mark + 650)
            add_random_text();

        // Second random part.
        mark = text_q.size();
        while (text_q.size() < mark + 200)
            add_random_text();

        total_bytes = text_q.size();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (sent_cnt != total_bytes || expected_tokens.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_cnt == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[filelist.f]
rtl/sst_pkg.sv
rtl/sst_byte_if.sv
rtl/sst_token_if.sv
rtl/sst_scan.sv
rtl/sst_fifo.sv
rtl/source_text_tokenizer.sv
verif/source_text_tokenizer_tb.sv
